### design/jsu_pkg.sv
// shared types and codes for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned JOB_MAX_BYTES = 4;

   // work for the back end caused by one input byte
   // mark is KIND_BYTE when no closing marker follows the bytes
   typedef struct packed {
      logic [2:0]                      nbytes;
      logic [JOB_MAX_BYTES-1:0][7:0]   bytes;
      logic [1:0]                      mark;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

### design/jsu_front.sv
// front end: escape and surrogate decoding of one byte per cycle, while accept is high, into jobs
`timescale 1ns / 1ps

module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       text_byte,
   input  logic             text_ends,
   output logic             job_valid,
   output jsu_pkg::job_type job
);
   import jsu_pkg::*;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_BODY     = 3'd1;
   localparam logic [2:0] PH_ESC      = 3'd2;
   localparam logic [2:0] PH_HEX_A    = 3'd3;
   localparam logic [2:0] PH_WANT_BSL = 3'd4;
   localparam logic [2:0] PH_WANT_U   = 3'd5;
   localparam logic [2:0] PH_HEX_B    = 3'd6;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [5:0] HIGH_SURR_TOP = 6'b110110;
   localparam logic [5:0] LOW_SURR_TOP  = 6'b110111;

   function automatic job_type utf8_encode(input logic [20:0] cp);
      job_type r;
      r = '0;
      r.mark = KIND_BYTE;
      if (cp <= 21'h7F) begin
         r.nbytes = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         r.nbytes = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         r.nbytes = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.nbytes = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] code_ff, code_in;
   logic [9:0]  high_ff, high_in;

   logic        hex_ok;
   logic [3:0]  hex_digit;
   logic [15:0] code_next;
   logic        bad, closed, enc_en;
   logic [20:0] cp;
   job_type     enc;
   job_type     plain;

   always_comb begin
      hex_ok = 1'b1;
      hex_digit = 4'd0;
      if (text_byte >= 8'h30 && text_byte <= 8'h39)
         hex_digit = text_byte[3:0];
      else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
               (text_byte >= 8'h41 && text_byte <= 8'h46))
         hex_digit = 4'(text_byte[2:0] + 3'd1) + 4'd8;
      else
         hex_ok = 1'b0;
   end

   assign code_next = {code_ff[11:0], hex_digit};
   assign enc = utf8_encode(cp);

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      code_in = code_ff;
      high_in = high_ff;
      plain = '0;
      plain.mark = KIND_BYTE;
      bad = 1'b0;
      closed = 1'b0;
      enc_en = 1'b0;
      cp = {5'd0, code_next};

      unique case (phase_ff)
         PH_BODY: begin
            if (text_byte == CH_BSL) begin
               phase_in = PH_ESC;
            end else if (text_byte == CH_QUOTE) begin
               closed = 1'b1;
            end else begin
               plain.nbytes = 3'd1;
               plain.bytes[0] = text_byte;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            plain.nbytes = 3'd1;
            unique case (text_byte)
               CH_B: plain.bytes[0] = 8'h08;
               CH_F: plain.bytes[0] = 8'h0C;
               CH_N: plain.bytes[0] = 8'h0A;
               CH_R: plain.bytes[0] = 8'h0D;
               CH_T: plain.bytes[0] = 8'h09;
               CH_U: begin
                  plain.nbytes = 3'd0;
                  phase_in = PH_HEX_A;
                  cnt_in = 2'd0;
                  code_in = 16'd0;
               end
               default: plain.bytes[0] = text_byte;
            endcase
         end
         PH_HEX_A, PH_HEX_B: begin
            if (!hex_ok) begin
               bad = 1'b1;
            end else begin
               code_in = code_next;
               if (cnt_ff != 2'd3) begin
                  cnt_in = cnt_ff + 2'd1;
               end else begin
                  cnt_in = 2'd0;
                  if (phase_ff == PH_HEX_A) begin
                     if (code_next[15:10] == HIGH_SURR_TOP) begin
                        high_in = code_next[9:0];
                        phase_in = PH_WANT_BSL;
                     end else begin
                        enc_en = 1'b1;
                        phase_in = PH_BODY;
                     end
                  end else if (code_next[15:10] != LOW_SURR_TOP) begin
                     bad = 1'b1;
                  end else begin
                     enc_en = 1'b1;
                     cp = 21'h10000 + {1'b0, high_ff, code_next[9:0]};
                     phase_in = PH_BODY;
                  end
               end
            end
         end
         PH_WANT_BSL: begin
            if (text_byte == CH_BSL) phase_in = PH_WANT_U;
            else bad = 1'b1;
         end
         PH_WANT_U: begin
            if (text_byte == CH_U) begin
               phase_in = PH_HEX_B;
               cnt_in = 2'd0;
               code_in = 16'd0;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            if (text_byte == CH_QUOTE) phase_in = PH_BODY;
            else bad = 1'b1;
         end
      endcase

      job = enc_en ? enc : plain;
      if (closed) begin
         job.mark = KIND_DONE;
         phase_in = PH_IDLE;
      end else if (bad || text_ends) begin
         job.mark = KIND_BAD;
         phase_in = PH_IDLE;
      end
      if (phase_in == PH_IDLE) cnt_in = 2'd0;
      job_valid = (job.nbytes != 3'd0) || (job.mark != KIND_BYTE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= code_in;
         high_ff <= high_in;
      end
   end

endmodule

### design/jsu_queue.sv
// job queue between the decoding front end and the output serializer
`timescale 1ns / 1ps

module jsu_queue #(
   parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::job_type    push_job,
   input  logic                pop,
   output jsu_pkg::job_type    head_job,
   output jsu_pkg::q_stat_type stat
);
   import jsu_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### design/jsu_back.sv
// back end: walks each job one result per cycle, while the output register is free or popped, into the output register
`timescale 1ns / 1ps

module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::job_type head_job,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic             rsp_run_last
);
   import jsu_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic [1:0] kind_ff;
   logic       last_ff;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       load, step, is_byte, is_last;

   assign load = !rsp_valid_ff || rsp_pop;
   assign step = load && !q_empty;
   assign total = head_job.nbytes + ((head_job.mark != KIND_BYTE) ? 3'd1 : 3'd0);
   assign is_byte = (idx_ff < head_job.nbytes);
   assign is_last = (idx_ff == total - 3'd1);
   assign q_pop = step && is_last;

   always_comb begin
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff <= is_byte ? head_job.bytes[idx_ff[1:0]] : 8'd0;
         kind_ff <= is_byte ? KIND_BYTE : head_job.mark;
         last_ff <= is_last;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_kind = kind_ff;
   assign rsp_run_last = last_ff;

endmodule

### design/json_string_unescape_utf8_core.sv
// top level of the json string unescaper with utf-8 output
`timescale 1ns / 1ps

// Takes the raw bytes of a quoted JSON string, one byte per transfer on the
// req_ side, and gives the decoded text as UTF-8 bytes on the rsp_ side,
// followed by one marker: kind 1 when the closing quote arrives, kind 2 when
// the string is malformed (missing opening quote, bad hex digit, broken
// surrogate pair, or text that ends before the closing quote). On a kind 2
// marker the consumer drops every byte it got for that string. Each input
// byte causes zero to five results; run_last flags the last one of them.
// The front end decodes one byte per cycle while the queue has room and
// turns it into a job; a job queue (QUEUE_DEPTH entries) sits between it and
// the serializer, which delivers one result per cycle through an output
// register while the consumer pops. An input byte is accepted every cycle as
// long as the queue has room, so the sustained input rate is one byte per
// cycle when each byte gives at most one result, and slower, at the
// serializer's pace of one result per cycle, when bytes give more. A result
// passes through the job queue and then the output register to the rsp_ ports.
module json_string_unescape_utf8_core #(
   parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_text_ends,
   // result channel
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_run_last
);
   import jsu_pkg::*;

   logic       in_xfer;     // input transfer this cycle
   logic       job_valid;   // this byte causes at least one result
   job_type    front_job;
   job_type    head_job;
   q_stat_type q_stat;
   logic       q_pop;

   // the queue's full flag is the only back-pressure on the input side
   assign req_full = q_stat.full;
   assign in_xfer = req_push && !q_stat.full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (in_xfer),
      .text_byte (req_text_byte),
      .text_ends (req_text_ends),
      .job_valid (job_valid),
      .job       (front_job)
   );

   // bytes that cause nothing (opening quote, escape backslash, a hex digit that completes no code point) leave no job
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (in_xfer && job_valid),
      .push_job (front_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .q_empty      (q_stat.empty),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_run_last (rsp_run_last)
   );

   // a marker always closes the run of results of its input byte
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != KIND_BYTE) |-> rsp_run_last)
      else $error("marker result without run_last");

   // markers carry a zero byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != KIND_BYTE) |-> (rsp_out_byte == 8'd0))
      else $error("marker result with nonzero byte");

   // the result kind is never the unused code
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_kind == KIND_BYTE || rsp_kind == KIND_DONE ||
                      rsp_kind == KIND_BAD))
      else $error("result with unused kind code");

   // queue flags are consistent
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("job queue both full and empty");

endmodule

### tb/sv/json_string_unescape_utf8_core_tb.sv
// testbench for the json string unescaper: predicted utf-8 results checked per transfer
`timescale 1ns / 1ps

module json_string_unescape_utf8_core_tb;
   import jsu_pkg::*;

   // source text characters the parser reacts to
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_LR    = 8'h72;
   localparam logic [7:0] CH_LT    = 8'h74;
   localparam logic [7:0] CH_LU    = 8'h75;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;

   // control bytes produced by the short escapes
   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_TAB = 8'h09;

   localparam logic [4:0] NOT_HEX = 5'd16;

   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 80;
   localparam int STREAM_ITEMS = 60;
   localparam int DRAIN_CYCLES = 16;

   typedef enum logic [3:0] {
      PH_IDLE, PH_BODY, PH_ESC, PH_HEX_A, PH_WANT_BSL, PH_WANT_U, PH_HEX_B
   } parse_phase_type;

   typedef struct {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       run_last;
   } utf8_result_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_text_ends = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_run_last;

   json_string_unescape_utf8_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_text_byte(req_text_byte),
      .req_text_ends(req_text_ends),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_run_last (rsp_run_last)
   );

   // predictor state, mirrors the parser after each accepted byte
   parse_phase_type parse_phase = PH_IDLE;
   logic [1:0]      digit_count = 2'd0;
   logic [15:0]     unit_value  = 16'h0000;
   logic [9:0]      high_bits   = 10'h000;

   utf8_result_type step_results[$];
   utf8_result_type expected_utf8[$];
   utf8_result_type got_want;

   int  errors = 0;
   int  accepted_items = 0;
   bit  no_idle = 1'b0;
   // receiver hold-off requests, counted so that only one process writes each side
   int  hold_asks = 0;
   int  hold_seen = 0;
   int  hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= CH_0 && b <= CH_9) return {1'b0, 4'(b - CH_0)};
      if (b >= CH_LA && b <= CH_LF) return {1'b0, 4'(b - CH_LA + 8'd10)};
      if (b >= CH_UA && b <= CH_UF) return {1'b0, 4'(b - CH_UA + 8'd10)};
      return NOT_HEX;
   endfunction

   function automatic void put_result(input logic [7:0] v, input logic [1:0] k);
      utf8_result_type r;
      r.out_byte = v;
      r.kind     = k;
      r.run_last = 1'b0;
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic void put_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         put_result(cp[7:0], KIND_BYTE);
      end else if (cp <= 21'h7FF) begin
         put_result({3'b110, cp[10:6]}, KIND_BYTE);
         put_result({2'b10, cp[5:0]}, KIND_BYTE);
      end else if (cp <= 21'hFFFF) begin
         put_result({4'b1110, cp[15:12]}, KIND_BYTE);
         put_result({2'b10, cp[11:6]}, KIND_BYTE);
         put_result({2'b10, cp[5:0]}, KIND_BYTE);
      end else begin
         put_result({5'b11110, cp[20:18]}, KIND_BYTE);
         put_result({2'b10, cp[17:12]}, KIND_BYTE);
         put_result({2'b10, cp[11:6]}, KIND_BYTE);
         put_result({2'b10, cp[5:0]}, KIND_BYTE);
      end
   endfunction

   // advance the parser by one accepted byte and queue what it should emit
   function automatic void decode_byte(input logic [7:0] b, input logic ends);
      logic       bad;
      logic       closed;
      logic [4:0] d;
      bad = 1'b0;
      closed = 1'b0;
      case (parse_phase)
         PH_BODY: begin
            if (b == CH_BSL) parse_phase = PH_ESC;
            else if (b == CH_QUOTE) closed = 1'b1;
            else put_result(b, KIND_BYTE);
         end
         PH_ESC: begin
            parse_phase = PH_BODY;
            case (b)
               CH_LB: put_result(CTL_BS, KIND_BYTE);
               CH_LF: put_result(CTL_FF, KIND_BYTE);
               CH_LN: put_result(CTL_LF, KIND_BYTE);
               CH_LR: put_result(CTL_CR, KIND_BYTE);
               CH_LT: put_result(CTL_TAB, KIND_BYTE);
               CH_LU: begin
                  parse_phase = PH_HEX_A;
                  digit_count = 2'd0;
                  unit_value = 16'h0000;
               end
               default: put_result(b, KIND_BYTE);
            endcase
         end
         PH_HEX_A, PH_HEX_B: begin
            d = hex_nibble(b);
            if (d == NOT_HEX) begin
               bad = 1'b1;
            end else begin
               unit_value = {unit_value[11:0], d[3:0]};
               if (digit_count != 2'd3) begin
                  digit_count = digit_count + 2'd1;
               end else begin
                  digit_count = 2'd0;
                  if (parse_phase == PH_HEX_A) begin
                     if (unit_value >= 16'hD800 && unit_value <= 16'hDBFF) begin
                        // high surrogate base is aligned, so the low ten bits are the offset
                        high_bits = unit_value[9:0];
                        parse_phase = PH_WANT_BSL;
                     end else begin
                        put_utf8({5'd0, unit_value});
                        parse_phase = PH_BODY;
                     end
                  end else if (unit_value < 16'hDC00 || unit_value > 16'hDFFF) begin
                     bad = 1'b1;
                  end else begin
                     put_utf8(21'h10000 + {high_bits, unit_value[9:0]});
                     parse_phase = PH_BODY;
                  end
               end
            end
         end
         PH_WANT_BSL: begin
            if (b == CH_BSL) parse_phase = PH_WANT_U;
            else bad = 1'b1;
         end
         PH_WANT_U: begin
            if (b == CH_LU) begin
               parse_phase = PH_HEX_B;
               digit_count = 2'd0;
               unit_value = 16'h0000;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            if (b == CH_QUOTE) parse_phase = PH_BODY;
            else bad = 1'b1;
         end
      endcase
      // closing quote wins over end of text
      if (closed) begin
         put_result(8'h00, KIND_DONE);
         parse_phase = PH_IDLE;
      end else if (bad || ends) begin
         put_result(8'h00, KIND_BAD);
         parse_phase = PH_IDLE;
      end
      if (parse_phase == PH_IDLE) digit_count = 2'd0;
      if (step_results.size() > 0) step_results[step_results.size() - 1].run_last = 1'b1;
      foreach (step_results[i]) expected_utf8.insert(expected_utf8.size(), step_results[i]);
      step_results.delete();
   endfunction

   // ---------------------------------------------------------------- result side

   // pops with random gaps, honors hold-off requests, checks every transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_utf8.size() == 0) begin
               $error("unexpected result: out_byte %02h kind %0d run_last %0b",
                      rsp_out_byte, rsp_kind, rsp_run_last);
               errors++;
            end else begin
               got_want = expected_utf8.pop_front();
               if (rsp_out_byte !== got_want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", got_want.out_byte, rsp_out_byte);
                  errors++;
               end
               if (rsp_kind !== got_want.kind) begin
                  $error("kind: expected %0d, got %0d", got_want.kind, rsp_kind);
                  errors++;
               end
               if (rsp_run_last !== got_want.run_last) begin
                  $error("run_last: expected %0b, got %0b", got_want.run_last, rsp_run_last);
                  errors++;
               end
            end
         end
         if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= no_idle || ($urandom_range(99) >= 8);
         end
      end
   end

   // ---------------------------------------------------------------- input side

   // offer one byte, maybe after a random gap, and wait for its transfer
   task automatic send_byte(input logic [7:0] b, input logic ends);
      if (!no_idle && $urandom_range(99) < 8) begin
         req_push <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_text_byte <= b;
      req_text_ends <= ends;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_byte(b, ends);
      accepted_items++;
   endtask

   task automatic send_str(input string s, input logic ends_last = 1'b0);
      foreach (s[i]) send_byte(s[i], ends_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_0 + 8'(n);
      return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(n) - 8'd10;
   endfunction

   // backslash-u escape, hex case picked at random per digit
   task automatic send_hex(input logic [15:0] v, input logic ends_last = 1'b0);
      send_byte(CH_BSL, 1'b0);
      send_byte(CH_LU, 1'b0);
      for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]), ends_last && i == 0);
   endtask

   function automatic logic [7:0] rand_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSL);
      return b;
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (hex_nibble(b) != NOT_HEX);
      return b;
   endfunction

   function automatic logic [15:0] rand_high();
      return 16'hD800 | 16'($urandom_range(1023));
   endfunction

   // one well-formed piece of string body
   task automatic send_token();
      logic [7:0]  b;
      logic [15:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: send_byte(rand_plain(), 1'b0);
         4, 5: begin
            case ($urandom_range(7))
               0: b = CH_QUOTE;
               1: b = CH_BSL;
               2: b = CH_SLASH;
               3: b = CH_LB;
               4: b = CH_LF;
               5: b = CH_LN;
               6: b = CH_LR;
               default: b = CH_LT;
            endcase
            send_byte(CH_BSL, 1'b0);
            send_byte(b, 1'b0);
         end
         6: begin
            // any other escaped byte passes through
            do b = 8'($urandom_range(255)); while (b == CH_LU);
            send_byte(CH_BSL, 1'b0);
            send_byte(b, 1'b0);
         end
         7, 8: begin
            // one, two or three byte encodings, lone low surrogates included
            do begin
               case ($urandom_range(2))
                  0: v = 16'($urandom_range(16'h7F));
                  1: v = 16'($urandom_range(16'h7FF, 16'h80));
                  default: v = 16'($urandom_range(16'hFFFF, 16'h800));
               endcase
            end while (v >= 16'hD800 && v <= 16'hDBFF);
            send_hex(v);
         end
         default: begin
            send_hex(rand_high());
            send_hex(16'hDC00 | 16'($urandom_range(1023)));
         end
      endcase
   endtask

   task automatic send_good_string();
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(8)) send_token();
      send_byte(CH_QUOTE, $urandom_range(3) == 0);
   endtask

   // a string that starts fine and then goes wrong
   task automatic send_broken_string();
      logic [7:0]  b;
      logic [15:0] v;
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(3)) send_token();
      case ($urandom_range(5))
         0: send_byte(rand_plain(), 1'b1);
         1: begin
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_LU, 1'b0);
            repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))), 1'b0);
            send_byte(rand_non_hex(), 1'b0);
         end
         2: begin
            send_hex(rand_high());
            do b = 8'($urandom_range(255)); while (b == CH_BSL);
            send_byte(b, 1'b0);
         end
         3: begin
            send_hex(rand_high());
            send_byte(CH_BSL, 1'b0);
            do b = 8'($urandom_range(255)); while (b == CH_LU);
            send_byte(b, 1'b0);
         end
         4: begin
            send_hex(rand_high());
            do v = 16'($urandom_range(16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
            send_hex(v);
         end
         default: begin
            // text ends inside the hex digits
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_LU, 1'b0);
            repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))), 1'b0);
            send_byte(hex_char(4'($urandom_range(15))), 1'b1);
         end
      endcase
   endtask

   // arbitrary bytes, the last one ending the text so the parser is idle after
   task automatic send_noise();
      int n;
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
   endtask

   task automatic send_mixed();
      int r;
      r = $urandom_range(99);
      if (r < 75) send_good_string();
      else if (r < 90) send_broken_string();
      else send_noise();
   endtask

   // ---------------------------------------------------------------- tests

   // raw bytes at both extremes and every short escape
   task automatic test_escapes();
      send_byte(CH_QUOTE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_str("\\\"\\\\\\/\\b\\f\\n\\r\\t\\q\"");
   endtask

   // every utf-8 length boundary, a lone low surrogate and both pair extremes
   task automatic test_unicode();
      send_byte(CH_QUOTE, 1'b0);
      send_hex(16'h0000);
      send_hex(16'h007F);
      send_hex(16'h0080);
      send_hex(16'h07FF);
      send_hex(16'h0800);
      send_hex(16'hFFFF);
      send_hex(16'hDC00);
      send_hex(16'hD800);
      send_hex(16'hDC00);
      send_hex(16'hDBFF);
      send_hex(16'hDFFF);
      send_byte(CH_QUOTE, 1'b0);
   endtask

   task automatic test_malformed();
      // missing opening quote
      send_str("x");
      // bad hex digit
      send_str("\"\\u12G");
      // high surrogate followed by something other than a backslash
      send_byte(CH_QUOTE, 1'b0);
      send_hex(16'hD800);
      send_str("x");
      // backslash after the high surrogate but no u
      send_byte(CH_QUOTE, 1'b0);
      send_hex(16'hDBFF);
      send_str("\\x");
      // second unit is not a low surrogate
      send_byte(CH_QUOTE, 1'b0);
      send_hex(16'hD800);
      send_hex(16'h0041);
      // text ends before the closing quote
      send_str("\"ab", 1'b1);
      send_str("\"", 1'b1);
      // four bytes of a pair, then the end-of-text marker: five results
      send_byte(CH_QUOTE, 1'b0);
      send_hex(16'hD83D);
      send_hex(16'hDE00, 1'b1);
      // closing quote on the last byte still closes properly
      send_str("\"\"", 1'b1);
      // bytes after a closed string, with no opening quote, are malformed
      send_str("z");
      send_str("y", 1'b1);
   endtask

   // receiver stalls while a long run of plain bytes keeps coming
   task automatic test_full_stall();
      hold_asks <= hold_asks + 1;
      send_byte(CH_QUOTE, 1'b0);
      repeat (40) send_byte(rand_plain(), 1'b0);
      send_byte(CH_QUOTE, 1'b0);
   endtask

   // sender goes quiet until everything has drained, then resumes
   task automatic test_drain_pause();
      req_push <= 1'b0;
      while (expected_utf8.size() != 0) @(posedge clock);
      @(posedge clock);
      send_good_string();
      send_good_string();
   endtask

   // back-to-back transfers on both sides
   task automatic test_streaming();
      int start;
      start = accepted_items;
      no_idle = 1'b1;
      while (accepted_items - start < STREAM_ITEMS) send_mixed();
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      int start;
      start = accepted_items;
      while (accepted_items - start < RANDOM_ITEMS) send_mixed();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escapes();
      test_unicode();
      test_malformed();
      test_full_stall();
      test_drain_pause();
      test_streaming();
      test_random();
      req_push <= 1'b0;
      while (expected_utf8.size() != 0) @(posedge clock);
      // any stray result after the last expected one is caught by the checker
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("json_string_unescape_utf8_core_tb passed");
      end else begin
         $display("json_string_unescape_utf8_core_tb failed");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("json_string_unescape_utf8_core_tb failed");
      $finish;
   end

endmodule
